/* sv/tlbpt_pkg.sv */
`default_nettype none

package tlbpt_pkg;

  // fixed field widths of the stream beats
  localparam int ADDR_W      = 16;
  localparam int PA_W        = 15;
  localparam int FN_W        = 7;
  localparam int EP_W        = 8;
  localparam int CNT_W       = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;
  localparam int PAD_W       = OUT_TDATA_W - (PA_W + FN_W + 3 + EP_W + 2 * CNT_W);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [CNT_W-1:0] faults_so_far;
    logic [CNT_W-1:0] hits_so_far;
    logic [EP_W-1:0]  evicted_page;
    logic             evict_valid;
    logic             page_fault;
    logic             tlb_hit;
    logic [FN_W-1:0]  frame_number;
    logic [PA_W-1:0]  physical_address;
  } out_beat_t;

endpackage

`default_nettype wire

/* sv/tlbpt_ram.sv */
`default_nettype none

module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/tlbpt_tlb.sv */
`default_nettype none

module tlbpt_tlb #(
  parameter int ENTRIES = 16,
  parameter int PG_W    = 8,
  parameter int FR_W    = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PG_W-1:0]    lookup_page,
  input  logic [FR_W-1:0]    cmp_frame,
  output logic [ENTRIES-1:0] first_oh,
  output logic [ENTRIES-1:0] frame_eq,
  input  logic               refill_en,
  input  logic [PG_W-1:0]    refill_page,
  input  logic [FR_W-1:0]    refill_frame
);

  import tlbpt_pkg::*;

  localparam int TI_W = $clog2(ENTRIES);

  logic [PG_W-1:0]    tag_r   [ENTRIES];
  logic [FR_W-1:0]    frame_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] match;
  logic [TI_W-1:0]    fill_r;
  logic [TI_W-1:0]    fill_nxt;

  // parallel tag compare, frame compare per entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]    = valid_r[i] && (tag_r[i] == lookup_page);
      frame_eq[i] = (frame_r[i] == cmp_frame);
    end
  end

  // lowest matching entry wins
  assign first_oh = match & (~match + ENTRIES'(1));

  // round-robin fill slot
  assign fill_nxt = (fill_r == TI_W'(ENTRIES - 1)) ? '0 : fill_r + TI_W'(1);

  // valid bits and fill pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else if (refill_en) begin
      valid_r[fill_r] <= 1'b1;
      fill_r          <= fill_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (refill_en) begin
      tag_r[fill_r]   <= refill_page;
      frame_r[fill_r] <= refill_frame;
    end
  end

endmodule

`default_nettype wire

/* sv/tlb_page_table_fifo_translate.sv */
`default_nettype none

// Demand-paging address translator with a TLB and FIFO frame replacement.
// in_* carries one logical address per beat; out_* returns one translation
// per address, in order, with hit/fault flags, the evicted page and the
// running hit and fault counters.
// Each address passes through accept (page table read issued), table data
// (owner read of the mapped frame issued), then the decide cycle, which
// checks residency, writes page table, frame owners and TLB, and loads the
// output register. The chain of the page-table read feeding the frame-owner
// read sets this sequence.
// The output register lets a new address be accepted while a result waits;
// if out_tready stays low, the next item holds in its decide cycle.
// After reset the page-table valid bits are cleared, one entry a cycle, through
// all PAGE_COUNT entries; in_tready stays low meanwhile. TLB valid bits, fill
// pointer, victim pointer and counters clear at once.
// PAGE_SIZE and PAGE_COUNT are powers of two.
module tlb_page_table_fifo_translate #(
  parameter int TLB_ENTRIES = 16,
  parameter int FRAMES      = 128,
  parameter int PAGE_COUNT  = 256,
  parameter int PAGE_SIZE   = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // logical_address[15:0]
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // physical_address[14:0], frame_number[21:15], tlb_hit[22], page_fault[23],
  // evict_valid[24], evicted_page[32:25], hits_so_far[48:33],
  // faults_so_far[64:49], zero fill[71:65]
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import tlbpt_pkg::*;

  localparam int OFF_W = $clog2(PAGE_SIZE);
  localparam int PG_W  = $clog2(PAGE_COUNT);
  localparam int FR_W  = $clog2(FRAMES);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_TAB,
    S_OWN
  } state_t;

  state_t state_r, state_nxt;

  logic [PG_W-1:0]        page_r;
  logic [OFF_W-1:0]       offset_r;
  logic [PG_W-1:0]        clr_idx_r;
  logic [ADDR_W-1:0]      quot;
  logic [PG_W-1:0]        in_page;
  logic                   accept;
  logic                   decide;

  logic                   tab_we;
  logic [PG_W-1:0]        tab_waddr;
  logic [FR_W:0]          tab_wdata;
  logic [FR_W:0]          tab_rd;
  logic [FR_W-1:0]        tf_r;
  logic                   tv_r;

  logic                   own_we;
  logic [FR_W-1:0]        own_a_addr;
  logic [PG_W-1:0]        own_a_rd;
  logic [PG_W-1:0]        own_b_rd;

  logic [TLB_ENTRIES-1:0] first_oh;
  logic [TLB_ENTRIES-1:0] first_oh_r;
  logic [TLB_ENTRIES-1:0] frame_eq;

  logic [FR_W-1:0]        nv_r;
  logic [FR_W-1:0]        nv_nxt;
  logic                   wrap_r;
  logic [CNT_W-1:0]       hits_r, hits_nxt;
  logic [CNT_W-1:0]       faults_r, faults_nxt;

  logic                   tf_used;
  logic                   resident;
  logic                   tlb_sel;
  logic                   fault;
  logic [FR_W-1:0]        frame_sel;
  logic [31:0]            pa_wide;
  logic [31:0]            fr_wide;
  logic [31:0]            ev_wide;

  logic                   out_tvalid_r;
  out_beat_t              out_beat_r, out_beat_nxt;

  // address split
  assign quot     = in_tdata >> OFF_W;
  assign in_page  = quot[PG_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign decide   = (state_r == S_OWN) && (!out_tvalid_r || out_tready);

  // page table: {valid, frame} per page
  always_comb begin
    if (state_r == S_CLR) begin
      tab_we    = 1'b1;
      tab_waddr = clr_idx_r;
      tab_wdata = '0;
    end else begin
      tab_we    = decide && fault;
      tab_waddr = page_r;
      tab_wdata = {1'b1, nv_r};
    end
  end

  tlbpt_ram #(
    .WIDTH (FR_W + 1),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_waddr),
    .wr_data (tab_wdata),
    .rd_addr (in_page),
    .rd_data (tab_rd)
  );

  // frame owners, one copy for the mapped frame, one for the victim
  assign own_we     = decide && fault;
  assign own_a_addr = (state_r == S_TAB) ? tab_rd[FR_W-1:0] : tf_r;

  tlbpt_ram #(
    .WIDTH (PG_W),
    .DEPTH (FRAMES)
  ) u_owner_map (
    .clk     (clk),
    .wr_en   (own_we),
    .wr_addr (nv_r),
    .wr_data (page_r),
    .rd_addr (own_a_addr),
    .rd_data (own_a_rd)
  );

  tlbpt_ram #(
    .WIDTH (PG_W),
    .DEPTH (FRAMES)
  ) u_owner_victim (
    .clk     (clk),
    .wr_en   (own_we),
    .wr_addr (nv_r),
    .wr_data (page_r),
    .rd_addr (nv_r),
    .rd_data (own_b_rd)
  );

  tlbpt_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .PG_W    (PG_W),
    .FR_W    (FR_W)
  ) u_tlb (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup_page  (page_r),
    .cmp_frame    (tf_r),
    .first_oh     (first_oh),
    .frame_eq     (frame_eq),
    .refill_en    (decide && !tlb_sel),
    .refill_page  (page_r),
    .refill_frame (frame_sel)
  );

  // residency and hit decision; frames are handed out in order, so a frame
  // is in use once the victim pointer has passed it or has wrapped
  assign tf_used   = wrap_r || (tf_r < nv_r);
  assign resident  = tv_r && tf_used && (own_a_rd == page_r);
  assign tlb_sel   = resident && (|(first_oh_r & frame_eq));
  assign fault     = !resident;
  assign frame_sel = fault ? nv_r : tf_r;
  assign nv_nxt    = (nv_r == FR_W'(FRAMES - 1)) ? '0 : nv_r + FR_W'(1);

  // saturating counters
  assign hits_nxt   = (tlb_sel && (hits_r != CNT_MAX)) ? hits_r + CNT_W'(1) : hits_r;
  assign faults_nxt = (fault && (faults_r != CNT_MAX)) ? faults_r + CNT_W'(1) : faults_r;

  // result beat
  assign pa_wide = (32'(frame_sel) << OFF_W) | 32'(offset_r);
  assign fr_wide = 32'(frame_sel);
  assign ev_wide = (fault && wrap_r) ? 32'(own_b_rd) : 32'd0;

  always_comb begin
    out_beat_nxt                  = '0;
    out_beat_nxt.physical_address = pa_wide[PA_W-1:0];
    out_beat_nxt.frame_number     = fr_wide[FN_W-1:0];
    out_beat_nxt.tlb_hit          = tlb_sel;
    out_beat_nxt.page_fault       = fault;
    out_beat_nxt.evict_valid      = fault && wrap_r;
    out_beat_nxt.evicted_page     = ev_wide[EP_W-1:0];
    out_beat_nxt.hits_so_far      = hits_nxt;
    out_beat_nxt.faults_so_far    = faults_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (clr_idx_r == PG_W'(PAGE_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_TAB;
      S_TAB:   state_nxt = S_OWN;
      S_OWN:   if (decide) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, pointers, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_idx_r    <= '0;
      nv_r         <= '0;
      wrap_r       <= 1'b0;
      hits_r       <= '0;
      faults_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_idx_r <= clr_idx_r + PG_W'(1);
      end
      if (accept) begin
        page_r   <= in_page;
        offset_r <= in_tdata[OFF_W-1:0];
      end
      if (state_r == S_TAB) begin
        tv_r       <= tab_rd[FR_W];
        tf_r       <= tab_rd[FR_W-1:0];
        first_oh_r <= first_oh;
      end
      if (decide) begin
        hits_r       <= hits_nxt;
        faults_r     <= faults_nxt;
        out_beat_r   <= out_beat_nxt;
        out_tvalid_r <= 1'b1;
        if (fault) begin
          nv_r <= nv_nxt;
          if (nv_r == FR_W'(FRAMES - 1)) begin
            wrap_r <= 1'b1;
          end
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_beat_r;

  // a result appears only out of a decide cycle
  a_valid_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_OWN))
    else $error("result beat raised outside decide cycle");

  // a hit is never a fault, an eviction is always a fault
  a_hit_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
    decide |-> !(tlb_sel && fault) && (!out_beat_nxt.evict_valid || fault))
    else $error("inconsistent hit, fault and evict flags");

  // the victim pointer moves only on a fault
  a_victim_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (nv_r != $past(nv_r)) |-> ($past(decide) && $past(fault)))
    else $error("victim pointer moved without a page fault");

endmodule

`default_nettype wire
